>>> rtl/range_sum_segment_tree_macros.svh
// ---------------------------------------------------------------------------
// range sum segment tree assertion macros
// shorthand for clocked assertions with synchronous active-low reset
// ---------------------------------------------------------------------------
`ifndef RANGE_SUM_SEGMENT_TREE_MACROS_SVH
`define RANGE_SUM_SEGMENT_TREE_MACROS_SVH

// consequent checked in the same cycle
`define RSST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define RSST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rsst_pkg.sv
// ---------------------------------------------------------------------------
// rsst_pkg
// shared sizes and codes of the range sum segment tree
// ---------------------------------------------------------------------------
package rsst_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
  localparam int NODE_AW      = $clog2(NODE_DEPTH);
  localparam int PTR_W        = NODE_AW + 1;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int DATA_W       = 32;
  localparam int CMP_W        = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

endpackage

>>> rtl/rsst_ram.sv
// ---------------------------------------------------------------------------
// rsst_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/range_sum_segment_tree.sv
// ---------------------------------------------------------------------------
// range_sum_segment_tree
// segment tree of wrapping 32-bit node sums with point update and range sum
// ---------------------------------------------------------------------------
// update: writes the leaf, then one parent sum per tree level up to the root, then the result
// query: walks the tree level by level, a left-edge step and a right-edge step per level
// error items: go straight to the result without touching the node store
// one item at a time, paced by the single read port and the one shared adder
// after reset a clearing pass zeroes the node store, in_stall high,
// configuration writes are taken throughout
module range_sum_segment_tree (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rsst_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [rsst_pkg::IDX_W-1:0]        in_first_index,
  input  logic [rsst_pkg::IDX_W-1:0]        in_last_index,
  input  logic signed [rsst_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rsst_pkg::DATA_W-1:0] out_range_sum,
  output logic                              out_error
);

  import rsst_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_UP_LEAF = 7'b0000100,
    S_UP_SUM  = 7'b0001000,
    S_Q_L     = 7'b0010000,
    S_Q_R     = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [NODE_AW-1:0]  clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload of the item in flight
  logic                kind_r, kind_nxt;
  logic                err_r, err_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic [PTR_W-1:0]    l_r, l_nxt;   // node pointer: leaf walk for updates, left edge for queries
  logic [PTR_W-1:0]    r_r, r_nxt;   // right edge of the half-open query span
  logic [DATA_W-1:0]   out_sum_r, out_sum_nxt;
  logic                out_err_r, out_err_nxt;

  // node store ports
  logic                ram_we;
  logic [NODE_AW-1:0]  ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [NODE_AW-1:0]  ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  // range checks and leaf positions of the incoming item
  logic [CMP_W-1:0]    live;
  logic [CMP_W-1:0]    first_x, last_x;
  logic                upd_bad, qry_bad, in_err, in_fire;
  logic [PTR_W-1:0]    leaf_l, leaf_r;

  // the one shared adder
  logic [DATA_W-1:0]   sum;
  logic [DATA_W-1:0]   acc_in;
  logic [PTR_W-1:0]    parent;
  logic [PTR_W-1:0]    r_dec;
  logic                out_free;

  rsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign in_fire       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;
  assign out_error     = out_err_r;

  // count above the tree size acts as the tree size
  assign live    = (CMP_W'(count_r) > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS)
                                                            : CMP_W'(count_r);
  assign first_x = CMP_W'(in_first_index);
  assign last_x  = CMP_W'(in_last_index);
  assign upd_bad = (first_x >= live);
  assign qry_bad = (first_x >= live) || (last_x >= live) || (first_x > last_x);
  assign in_err  = (in_kind == KIND_QUERY) ? qry_bad : upd_bad;

  // leaves sit at MAX_ELEMENTS + index, query span is half-open
  assign leaf_l = PTR_W'(MAX_ELEMENTS) + PTR_W'(in_first_index);
  assign leaf_r = PTR_W'(MAX_ELEMENTS) + PTR_W'(in_last_index) + PTR_W'(1);

  assign sum    = acc_r + ram_rdata;
  assign acc_in = pend_r ? sum : acc_r;
  assign parent = l_r >> 1;
  assign r_dec  = r_r - PTR_W'(1);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_wr_en ? cfg_wr_data : count_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    l_nxt         = l_r;
    r_nxt         = r_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = l_r[NODE_AW-1:0];
    ram_wdata     = acc_r;
    ram_re        = 1'b0;
    ram_raddr     = l_r[NODE_AW-1:0];

    case (state_r)
      S_CLEAR: begin
        // zero one node per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + NODE_AW'(1);
        if (clr_r == {NODE_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_kind;
          err_nxt  = in_err;
          acc_nxt  = (in_kind == KIND_UPDATE) ? $unsigned(in_value) : '0;
          l_nxt    = leaf_l;
          r_nxt    = leaf_r;
          if (in_err) begin
            state_nxt = S_DONE;
          end else if (in_kind == KIND_UPDATE) begin
            state_nxt = S_UP_LEAF;
          end else begin
            state_nxt = S_Q_L;
          end
        end
      end

      S_UP_LEAF: begin
        // write the leaf, fetch its sibling
        ram_we    = 1'b1;
        ram_waddr = l_r[NODE_AW-1:0];
        ram_wdata = acc_r;
        ram_re    = 1'b1;
        ram_raddr = {l_r[NODE_AW-1:1], ~l_r[0]};
        state_nxt = S_UP_SUM;
      end

      S_UP_SUM: begin
        // fresh child plus sibling gives the parent; fetch the parent's sibling unless it is the root
        ram_we    = 1'b1;
        ram_waddr = parent[NODE_AW-1:0];
        ram_wdata = sum;
        acc_nxt   = sum;
        l_nxt     = parent;
        if (parent == PTR_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {parent[NODE_AW-1:1], ~parent[0]};
        end
      end

      S_Q_L: begin
        acc_nxt = acc_in;
        if (l_r >= r_r) begin
          state_nxt = S_DONE;
        end else begin
          // left edge on a right child: take it and step past
          if (l_r[0]) begin
            ram_re    = 1'b1;
            ram_raddr = l_r[NODE_AW-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + PTR_W'(1);
          end
          state_nxt = S_Q_R;
        end
      end

      S_Q_R: begin
        acc_nxt = acc_in;
        // right edge odd: take the node just left of it
        if (r_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = r_dec[NODE_AW-1:0];
          pend_nxt  = 1'b1;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = S_Q_L;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = ((kind_r == KIND_QUERY) && !err_r) ? acc_r : '0;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      count_r     <= COUNT_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    err_r     <= err_nxt;
    acc_r     <= acc_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

>>> rtl/rsst_checker.sv
// ---------------------------------------------------------------------------
// rsst_checker
// port-level assertions for the range sum segment tree, bound to the top level
// ---------------------------------------------------------------------------
`include "range_sum_segment_tree_macros.svh"

module rsst_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [rsst_pkg::DATA_W-1:0] out_range_sum,
  input logic                               out_error
);

  // stalled result holds
  `RSST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_range_sum) && $stable(out_error), "stalled result changed")

  // an error result carries a zero sum
  `RSST_ASSERT_SAME(a_err_zero, out_valid && out_error, out_range_sum == 0, "error result with nonzero sum")

  // one item at a time: busy after every input transfer
  `RSST_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "input taken while an item is in flight")

endmodule

bind range_sum_segment_tree rsst_checker u_rsst_checker (.*);
